// File: design/fragment_reassembly_table_macros.svh
// assertion macros shared by the reassembly table modules
`ifndef FRAGMENT_REASSEMBLY_TABLE_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TABLE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define FRT_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define FRT_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error(msg);

`endif

// File: design/frt_pkg.sv
// shared constants, types and codes of the fragment reassembly table
package frt_pkg;

  localparam int MAX_CONTEXTS   = 4;
  localparam int MAX_FRAGMENTS  = 16;
  localparam int FRAGMENT_BYTES = 64;

  localparam int CTX_W  = (MAX_CONTEXTS > 1) ? $clog2(MAX_CONTEXTS) : 1;
  localparam int FRAG_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int OFF_W  = (FRAGMENT_BYTES > 1) ? $clog2(FRAGMENT_BYTES) : 1;
  localparam int SLEN_W = $clog2(FRAGMENT_BYTES + 1);
  localparam int CNT_W  = $clog2(MAX_FRAGMENTS + 1);
  localparam int LEN_W  = 11;
  localparam int KIND_W = 3;

  localparam int PAY_AW    = CTX_W + FRAG_W + OFF_W;
  localparam int PAY_DEPTH = MAX_CONTEXTS * MAX_FRAGMENTS * FRAGMENT_BYTES;
  localparam int SLEN_AW   = CTX_W + FRAG_W;
  localparam int SLEN_DEPTH = MAX_CONTEXTS * MAX_FRAGMENTS;

  typedef enum logic [KIND_W-1:0] {
    KIND_TAKEN    = 3'd0,
    KIND_STORED   = 3'd1,
    KIND_DUP      = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_BAD      = 3'd4,
    KIND_COMPLETE = 3'd5,
    KIND_OUT_BYTE = 3'd6,
    KIND_IDLE     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ACT_IDLE    = 2'd0,
    ACT_STORE   = 2'd1,
    ACT_DISCARD = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic drain_read;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode;
    logic need_read;
  } status_t;

endpackage

// File: design/frt_ram.sv
// generic simple dual-port ram with registered read
module frt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/frt_ctrl.sv
// sequencing state machine of the reassembly table
`include "fragment_reassembly_table_macros.svh"
module frt_ctrl import frt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = (status_i.mode && status_i.need_read) ? ST_READ : ST_OUT;
      end
      ST_READ: begin
        cmd_o.drain_read = 1'b1;
        state_d          = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `FRT_ASSERT_IMP(a_no_overlap, out_valid_o, !in_ready_o, "input taken while result pending")
  `FRT_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "ready after take")
  `FRT_ASSERT_NEXT(a_free_after_out, out_valid_o && out_ready_i, in_ready_o, "not ready after out")

endmodule

// File: design/frt_datapath.sv
// context table, payload stores, drain pointers and result register
`include "fragment_reassembly_table_macros.svh"
module frt_datapath import frt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              mode_i,
  input  logic [31:0]       sequence_number_i,
  input  logic [31:0]       source_address_i,
  input  logic [7:0]        fragment_number_i,
  input  logic [7:0]        fragment_total_i,
  input  logic [7:0]        data_byte_i,
  input  logic              fragment_end_i,
  output logic [KIND_W-1:0] kind_o,
  output logic [CTX_W-1:0]  context_slot_o,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic [LEN_W-1:0]  datagram_length_o
);

  // captured word
  logic        mode_q;
  logic [31:0] seq_q, src_q;
  logic [7:0]  num_q, tot_q, byte_q;
  logic        end_q;

  // context table
  logic [MAX_CONTEXTS-1:0]  valid_q, valid_d, cmpl_q, cmpl_d;
  logic [31:0]              ctx_seq_q [MAX_CONTEXTS];
  logic [31:0]              ctx_src_q [MAX_CONTEXTS];
  logic                     ctx_wr;
  logic [CTX_W-1:0]         ctx_wr_idx;
  logic [MAX_FRAGMENTS-1:0] map_q [MAX_CONTEXTS];
  logic [MAX_FRAGMENTS-1:0] map_d [MAX_CONTEXTS];
  logic [CNT_W-1:0]         cnt_q [MAX_CONTEXTS];
  logic [CNT_W-1:0]         cnt_d [MAX_CONTEXTS];
  logic [LEN_W-1:0]         dlen_q [MAX_CONTEXTS];
  logic [LEN_W-1:0]         dlen_d [MAX_CONTEXTS];

  // write and drain pointers
  logic [CTX_W-1:0]  wctx_q, wctx_d, dctx_q, dctx_d;
  logic [SLEN_W-1:0] woff_q, woff_d;
  act_e              wact_q, wact_d;
  logic [FRAG_W-1:0] wfrag_q, wfrag_d, dfrag_q, dfrag_d;
  logic [7:0]        wtot_q, wtot_d;
  logic              dact_q, dact_d;
  logic [OFF_W-1:0]  doff_q, doff_d;

  // result register
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [CTX_W-1:0]  slot_q, slot_d;
  logic [7:0]        obyte_q, obyte_d;
  logic              olast_q, olast_d;
  logic [LEN_W-1:0]  olen_q, olen_d;

  // memories
  logic              pay_we, slen_we;
  logic [PAY_AW-1:0] pay_waddr, pay_raddr;
  logic [7:0]        pay_rdata;
  logic [SLEN_AW-1:0] slen_waddr, slen_raddr;
  logic [SLEN_W-1:0] slen_wdata, slen_rdata;
  logic              need_read;

  // context searches
  logic             match_found, free_found, cmpl_found;
  logic [CTX_W-1:0] match_idx, free_idx, cmpl_idx;
  logic             hdr_bad;
  logic [FRAG_W-1:0] frag_idx;

  // first present fragment at or above a position
  function automatic logic [FRAG_W:0] find_present(logic [MAX_FRAGMENTS-1:0] map,
                                                   logic [FRAG_W:0] from);
    logic [FRAG_W:0] res;
    res = '0;
    for (int i = MAX_FRAGMENTS - 1; i >= 0; i--) begin
      if (map[i] && ((FRAG_W+1)'(i) >= from)) begin
        res = {1'b1, FRAG_W'(i)};
      end
    end
    return res;
  endfunction

  frt_ram #(.Width(8), .Depth(PAY_DEPTH)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (byte_q),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  frt_ram #(.Width(SLEN_W), .Depth(SLEN_DEPTH)) u_slen_ram (
    .clk_i   (clk_i),
    .we_i    (slen_we),
    .waddr_i (slen_waddr),
    .wdata_i (slen_wdata),
    .raddr_i (slen_raddr),
    .rdata_o (slen_rdata)
  );

  // header check and parallel context compare
  always_comb begin
    hdr_bad = (num_q == 8'd0) || (num_q > 8'(MAX_FRAGMENTS)) || (tot_q == 8'd0) ||
              (tot_q > 8'(MAX_FRAGMENTS)) || (num_q > tot_q);
    frag_idx    = FRAG_W'(num_q - 8'd1);
    match_found = 1'b0;
    match_idx   = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    cmpl_found  = 1'b0;
    cmpl_idx    = '0;
    for (int c = MAX_CONTEXTS - 1; c >= 0; c--) begin
      if (valid_q[c] && !cmpl_q[c] && (ctx_seq_q[c] == seq_q) && (ctx_src_q[c] == src_q)) begin
        match_found = 1'b1;
        match_idx   = CTX_W'(c);
      end
      if (!valid_q[c]) begin
        free_found = 1'b1;
        free_idx   = CTX_W'(c);
      end
      if (valid_q[c] && cmpl_q[c]) begin
        cmpl_found = 1'b1;
        cmpl_idx   = CTX_W'(c);
      end
    end
  end

  // one step of the write side or the drain side
  always_comb begin
    logic             go_store;
    logic [CTX_W-1:0] c;
    logic [FRAG_W-1:0] f;
    logic [SLEN_W-1:0] off, off_n;
    logic [CNT_W-1:0] cnt_n;
    logic [LEN_W-1:0] dlen_n;
    logic [7:0]       tot_use;
    logic [FRAG_W:0]  pres;

    valid_d = valid_q;
    cmpl_d  = cmpl_q;
    map_d   = map_q;
    cnt_d   = cnt_q;
    dlen_d  = dlen_q;
    wctx_d  = wctx_q;
    woff_d  = woff_q;
    wact_d  = wact_q;
    wfrag_d = wfrag_q;
    wtot_d  = wtot_q;
    dact_d  = dact_q;
    dctx_d  = dctx_q;
    dfrag_d = dfrag_q;
    doff_d  = doff_q;
    kind_d  = kind_q;
    slot_d  = slot_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    olen_d  = olen_q;
    ctx_wr     = 1'b0;
    ctx_wr_idx = '0;
    pay_we     = 1'b0;
    pay_waddr  = '0;
    pay_raddr  = {dctx_q, dfrag_q, doff_q};
    slen_we    = 1'b0;
    slen_waddr = '0;
    slen_wdata = '0;
    slen_raddr = {dctx_q, dfrag_q};
    need_read  = 1'b0;
    go_store   = 1'b0;
    c       = wctx_q;
    f       = wfrag_q;
    off     = woff_q;
    off_n   = '0;
    cnt_n   = '0;
    dlen_n  = '0;
    tot_use = wtot_q;
    pres    = '0;

    if (cmd_i.exec && !mode_q) begin
      kind_d  = KIND_TAKEN;
      slot_d  = '0;
      obyte_d = '0;
      olast_d = 1'b0;
      olen_d  = '0;
      case (wact_q)
        ACT_DISCARD: begin
          if (end_q) begin
            wact_d = ACT_IDLE;
          end
        end
        ACT_STORE: go_store = 1'b1;
        default: begin
          // first word of a fragment: header check, lookup, allocation
          if (hdr_bad) begin
            kind_d = KIND_BAD;
            wact_d = end_q ? ACT_IDLE : ACT_DISCARD;
          end else if (!match_found && !free_found) begin
            kind_d = KIND_FULL;
            wact_d = end_q ? ACT_IDLE : ACT_DISCARD;
          end else begin
            c = match_found ? match_idx : free_idx;
            if (!match_found) begin
              valid_d[c] = 1'b1;
              cmpl_d[c]  = 1'b0;
              map_d[c]   = '0;
              cnt_d[c]   = '0;
              dlen_d[c]  = '0;
              ctx_wr     = 1'b1;
              ctx_wr_idx = c;
            end
            if (match_found && map_q[c][frag_idx]) begin
              kind_d = KIND_DUP;
              slot_d = c;
              wact_d = end_q ? ACT_IDLE : ACT_DISCARD;
            end else begin
              f       = frag_idx;
              off     = '0;
              tot_use = tot_q;
              wctx_d  = c;
              wfrag_d = frag_idx;
              wtot_d  = tot_q;
              go_store = 1'b1;
            end
          end
        end
      endcase

      if (go_store) begin
        slot_d = c;
        if (off >= SLEN_W'(FRAGMENT_BYTES)) begin
          // oversize fragment: drop it, release an empty context
          if (cnt_q[c] == '0) begin
            valid_d[c] = 1'b0;
            cmpl_d[c]  = 1'b0;
            map_d[c]   = '0;
            cnt_d[c]   = '0;
            dlen_d[c]  = '0;
          end
          kind_d = KIND_BAD;
          wact_d = end_q ? ACT_IDLE : ACT_DISCARD;
        end else begin
          pay_we    = 1'b1;
          pay_waddr = {c, f, off[OFF_W-1:0]};
          off_n     = off + SLEN_W'(1);
          if (!end_q) begin
            woff_d = off_n;
            wact_d = ACT_STORE;
          end else begin
            cnt_n      = cnt_q[c] + CNT_W'(1);
            dlen_n     = dlen_q[c] + LEN_W'(off_n);
            map_d[c][f] = 1'b1;
            cnt_d[c]   = cnt_n;
            dlen_d[c]  = dlen_n;
            slen_we    = 1'b1;
            slen_waddr = {c, f};
            slen_wdata = off_n;
            wact_d     = ACT_IDLE;
            woff_d     = '0;
            if (8'(cnt_n) != tot_use) begin
              kind_d = KIND_STORED;
            end else begin
              cmpl_d[c] = 1'b1;
              kind_d    = KIND_COMPLETE;
              olen_d    = dlen_n;
            end
          end
        end
      end
    end

    // drain, execute step: pick the context and address the memories
    if (cmd_i.exec && mode_q) begin
      kind_d  = KIND_IDLE;
      slot_d  = '0;
      obyte_d = '0;
      olast_d = 1'b0;
      olen_d  = '0;
      if (dact_q) begin
        need_read = 1'b1;
      end else if (cmpl_found) begin
        pres = find_present(map_q[cmpl_idx], '0);
        if (pres[FRAG_W]) begin
          dact_d     = 1'b1;
          dctx_d     = cmpl_idx;
          dfrag_d    = pres[FRAG_W-1:0];
          doff_d     = '0;
          pay_raddr  = {cmpl_idx, pres[FRAG_W-1:0], OFF_W'(0)};
          slen_raddr = {cmpl_idx, pres[FRAG_W-1:0]};
          need_read  = 1'b1;
        end else begin
          valid_d[cmpl_idx] = 1'b0;
          cmpl_d[cmpl_idx]  = 1'b0;
          map_d[cmpl_idx]   = '0;
          cnt_d[cmpl_idx]   = '0;
          dlen_d[cmpl_idx]  = '0;
        end
      end
    end

    // drain, read step: emit the byte and advance
    if (cmd_i.drain_read) begin
      kind_d  = KIND_OUT_BYTE;
      slot_d  = dctx_q;
      obyte_d = pay_rdata;
      olast_d = 1'b0;
      olen_d  = '0;
      if ((SLEN_W'(doff_q) + SLEN_W'(1)) < slen_rdata) begin
        doff_d = doff_q + OFF_W'(1);
      end else begin
        pres = find_present(map_q[dctx_q], (FRAG_W+1)'(dfrag_q) + (FRAG_W+1)'(1));
        if (pres[FRAG_W]) begin
          dfrag_d = pres[FRAG_W-1:0];
          doff_d  = '0;
        end else begin
          valid_d[dctx_q] = 1'b0;
          cmpl_d[dctx_q]  = 1'b0;
          map_d[dctx_q]   = '0;
          cnt_d[dctx_q]   = '0;
          dlen_d[dctx_q]  = '0;
          dact_d  = 1'b0;
          doff_d  = '0;
          dfrag_d = '0;
          olast_d = 1'b1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cmpl_q  <= '0;
      for (int i = 0; i < MAX_CONTEXTS; i++) begin
        map_q[i]  <= '0;
        cnt_q[i]  <= '0;
        dlen_q[i] <= '0;
      end
      wctx_q  <= '0;
      woff_q  <= '0;
      wact_q  <= ACT_IDLE;
      wfrag_q <= '0;
      wtot_q  <= '0;
      dact_q  <= 1'b0;
      dctx_q  <= '0;
      dfrag_q <= '0;
      doff_q  <= '0;
    end else begin
      valid_q <= valid_d;
      cmpl_q  <= cmpl_d;
      map_q   <= map_d;
      cnt_q   <= cnt_d;
      dlen_q  <= dlen_d;
      wctx_q  <= wctx_d;
      woff_q  <= woff_d;
      wact_q  <= wact_d;
      wfrag_q <= wfrag_d;
      wtot_q  <= wtot_d;
      dact_q  <= dact_d;
      dctx_q  <= dctx_d;
      dfrag_q <= dfrag_d;
      doff_q  <= doff_d;
    end
  end

  // captured word, keys and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      seq_q  <= sequence_number_i;
      src_q  <= source_address_i;
      num_q  <= fragment_number_i;
      tot_q  <= fragment_total_i;
      byte_q <= data_byte_i;
      end_q  <= fragment_end_i;
    end
    if (ctx_wr) begin
      ctx_seq_q[ctx_wr_idx] <= seq_q;
      ctx_src_q[ctx_wr_idx] <= src_q;
    end
    kind_q  <= kind_d;
    slot_q  <= slot_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    olen_q  <= olen_d;
  end

  assign status_o.mode      = mode_q;
  assign status_o.need_read = need_read;

  assign kind_o            = kind_q;
  assign context_slot_o    = slot_q;
  assign out_byte_o        = obyte_q;
  assign out_last_o        = olast_q;
  assign datagram_length_o = olen_q;

  `FRT_ASSERT_IMP(a_drain_ctx_ok, dact_q, valid_q[dctx_q] && cmpl_q[dctx_q], "drain on open context")
  `FRT_ASSERT_IMP(a_store_ctx_ok, wact_q == ACT_STORE, valid_q[wctx_q] && !cmpl_q[wctx_q], "store into closed context")
  `FRT_ASSERT_IMP(a_read_in_drain, cmd_i.drain_read, dact_q, "drain read with no drain running")

endmodule

// File: design/fragment_reassembly_table.sv
// top level of the fragment reassembly table
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------------
//   input    | in_valid_i / in_ready_o  | mode, key, fragment number/total, byte, end
//   output   | out_valid_o / out_ready_i| kind, context slot, byte, last, length
//
// a fragment word passes through capture, execute and present; a drain tick that
// sends a byte adds a read step after execute, the registered read of the payload
// and length memories, and a drain tick with nothing to send skips that step.
// one word is in flight at a time; the result is held while out_ready_i is low,
// and the input side is held off until the result is taken.
// reset clears the context table at once; the memories need no clearing pass.
module fragment_reassembly_table import frt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [31:0]       sequence_number_i,
  input  logic [31:0]       source_address_i,
  input  logic [7:0]        fragment_number_i,
  input  logic [7:0]        fragment_total_i,
  input  logic [7:0]        data_byte_i,
  input  logic              fragment_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic [CTX_W-1:0]  context_slot_o,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic [LEN_W-1:0]  datagram_length_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  frt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // tables and stores
  frt_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .mode_i            (mode_i),
    .sequence_number_i (sequence_number_i),
    .source_address_i  (source_address_i),
    .fragment_number_i (fragment_number_i),
    .fragment_total_i  (fragment_total_i),
    .data_byte_i       (data_byte_i),
    .fragment_end_i    (fragment_end_i),
    .kind_o            (kind_o),
    .context_slot_o    (context_slot_o),
    .out_byte_o        (out_byte_o),
    .out_last_o        (out_last_o),
    .datagram_length_o (datagram_length_o)
  );

endmodule
